// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the compensation core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CHK_IMPLY(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/btpc_pkg.sv -----
package btpc_pkg;

   localparam int unsigned RAW_W = 19;
   localparam int unsigned WORD_W = 32;

   // register indexes on the csr channel
   localparam logic [2:0] CSR_OSS = 3'd0;
   localparam logic [2:0] CSR_A1 = 3'd1;
   localparam logic [2:0] CSR_A2 = 3'd2;
   localparam logic [2:0] CSR_A3 = 3'd3;
   localparam logic [2:0] CSR_A4 = 3'd4;
   localparam logic [2:0] CSR_A5A6 = 3'd5;
   localparam logic [2:0] CSR_B1B2 = 3'd6;
   localparam logic [2:0] CSR_MCMD = 3'd7;

   localparam logic KIND_TEMP = 1'b0;

   localparam logic [31:0] TEMP_OFS = 32'd4000;
   localparam logic [31:0] HALF_SCALE = 32'd32768;
   localparam logic [31:0] PRESS_K = 32'd50000;
   localparam logic [31:0] POLY_A = 32'd3038;
   localparam logic [31:0] POLY_B = 32'hFFFF_E343; // -7357
   localparam logic [31:0] POLY_C = 32'd3791;

   // datapath step codes, in sequence order
   typedef enum logic [4:0] {
      OP_NONE,
      T_MUL, T_X1, T_DEN, T_FIN,
      P_B6, P_SQMUL, P_SQ, P_X1MUL, P_X2MUL, P_B3, P_X2B, P_X3,
      P_B4MUL, P_B4, P_B7MUL, P_B7, P_PFIX, P_PSQ, P_P3038, P_X1C, P_FIN
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE, S_RUN, S_DIV, S_OUT
   } state_type;

   typedef struct packed {
      op_type op;
      logic   load;
      logic   div_start;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic b4_zero;
      logic div_done;
   } sts_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
      asr = $signed(x) >>> n;
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] x);
      sx16 = {{16{x[15]}}, x};
   endfunction

endpackage

// ----- rtl/core/baro_temp_pressure_compensation.sv -----
// Temperature and pressure requests each run as a sequence of datapath steps.
// The steps use the 32-step radix-2 divider and the one shared 32x32 multiplier.
// One request at a time: a new one is accepted only after the previous result is taken.
// Reset (synchronous, active high) clears calibration registers, oversampling
// and the kept temperature term to zero.
`include "assert_macros.svh"
module baro_temp_pressure_compensation
   import btpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [18:0] raw_value, zero pad
   input  logic [0:0]  req_tuser,  // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] value
   output logic [1:0]  rsp_tuser,  // [0] kind, [1] divide_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;
   logic    kind, err;

   assign csr_ready = 1'b1;

   btpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (req_tuser[0]),
      .req_ready  (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   btpc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_action (req_tuser[0]),
      .in_raw    (req_tdata[RAW_W-1:0]),
      .csr_we    (csr_valid),
      .csr_idx   (csr_index),
      .csr_data  (csr_wdata),
      .out_kind  (kind),
      .out_value (rsp_tdata),
      .out_err   (err)
   );

   assign rsp_tuser = {err, kind};

   // no new request while a result waits, and work never overlaps a result
   `CHK_IMPLY(a_no_req_with_rsp, clock, reset, rsp_tvalid, !req_tready)
   `CHK_NEXT(a_load_starts_work, clock, reset, cmd.load, !rsp_tvalid)
   `CHK_IMPLY(a_div_start_busy, clock, reset, cmd.div_start, !rsp_tvalid && !req_tready)

endmodule

// ----- rtl/core/btpc_div.sv -----
module btpc_div
   import btpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic [31:0] quotient,
   output logic        done
);

   logic [31:0] rem_ff, quo_ff, dvs_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [32:0] rem_sh, diff;
   logic        ge;

   // one restoring step per cycle
   always_comb begin
      rem_sh = {rem_ff, quo_ff[31]};
      diff = rem_sh - {1'b0, dvs_ff};
      ge = ~diff[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 5'd31);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[31:0] : rem_sh[31:0];
         quo_ff <= {quo_ff[30:0], ge};
      end
   end

   assign quotient = quo_ff;
   assign done = done_ff;

endmodule

// ----- rtl/core/btpc_dp.sv -----
module btpc_dp
   import btpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic             in_action,
   input  logic [RAW_W-1:0] in_raw,
   input  logic             csr_we,
   input  logic [2:0]       csr_idx,
   input  logic [31:0]      csr_data,
   output logic             out_kind,
   output logic [31:0]      out_value,
   output logic             out_err
);

   logic [1:0]  oss_ff;
   logic [15:0] a1_ff, a2_ff, a3_ff, a4_ff;
   logic [31:0] a5a6_ff, b1b2_ff, mcmd_ff;

   logic [RAW_W-1:0] raw_ff;
   logic        kind_ff, err_ff, neg_ff, pmsb_ff;
   logic [31:0] temp_term_ff, mul_ff, x1_ff, sq_ff, b6_ff, b3_ff, b4_ff, p_ff, val_ff;

   logic [31:0] mul_a, mul_b, mul_in, raw_w, den, num, q, b5, quo;
   logic [31:0] div_a, div_b, b3_sum;
   logic        div_done;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
         a3_ff <= '0;
         a4_ff <= '0;
         a5a6_ff <= '0;
         b1b2_ff <= '0;
         mcmd_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_OSS:  oss_ff <= csr_data[1:0];
            CSR_A1:   a1_ff <= csr_data[15:0];
            CSR_A2:   a2_ff <= csr_data[15:0];
            CSR_A3:   a3_ff <= csr_data[15:0];
            CSR_A4:   a4_ff <= csr_data[15:0];
            CSR_A5A6: a5a6_ff <= csr_data;
            CSR_B1B2: b1b2_ff <= csr_data;
            CSR_MCMD: mcmd_ff <= csr_data;
            default:  ;
         endcase
      end
   end

   // combinational terms
   always_comb begin
      raw_w = {{(WORD_W-RAW_W){1'b0}}, raw_ff};
      den = x1_ff + sx16(mcmd_ff[15:0]);
      num = sx16(mcmd_ff[31:16]) << 11;
      q = neg_ff ? (32'd0 - quo) : quo;
      b5 = x1_ff + q;
      b3_sum = (sx16(a1_ff) << 2) + x1_ff + asr(mul_ff, 5'd11);
      div_b = b4_ff;
      if (cmd.op == T_DEN) begin
         div_a = num[31] ? (32'd0 - num) : num;
         div_b = den[31] ? (32'd0 - den) : den;
      end else begin
         div_a = mul_ff[31] ? mul_ff : {mul_ff[30:0], 1'b0};
      end
   end

   // shared multiplier operands
   always_comb begin
      mul_a = mul_ff;
      mul_b = mul_ff;
      unique case (cmd.op)
         T_MUL: begin
            mul_a = raw_w - {16'd0, a5a6_ff[15:0]};
            mul_b = {16'd0, a5a6_ff[31:16]};
         end
         P_SQMUL: begin mul_a = b6_ff; mul_b = b6_ff; end
         P_X1MUL: begin mul_a = sx16(b1b2_ff[15:0]); mul_b = sq_ff; end
         P_X2MUL: begin mul_a = sx16(a2_ff); mul_b = b6_ff; end
         P_B3:    begin mul_a = sx16(a3_ff); mul_b = b6_ff; end
         P_X2B:   begin mul_a = sx16(b1b2_ff[31:16]); mul_b = sq_ff; end
         P_B4MUL: begin mul_a = {16'd0, a4_ff}; mul_b = x1_ff + HALF_SCALE; end
         P_B7MUL: begin mul_a = raw_w - b3_ff; mul_b = PRESS_K >> oss_ff; end
         P_PSQ:   begin mul_a = asr(p_ff, 5'd8); mul_b = asr(p_ff, 5'd8); end
         P_P3038: begin mul_a = mul_ff; mul_b = POLY_A; end
         P_X1C:   begin mul_a = POLY_B; mul_b = p_ff; end
         default: ;
      endcase
      mul_in = mul_a * mul_b;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_term_ff <= '0;
      end else if (cmd.op == T_FIN) begin
         temp_term_ff <= b5;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff <= in_raw;
         kind_ff <= in_action;
      end
      mul_ff <= mul_in;
      unique case (cmd.op)
         T_X1:  x1_ff <= asr(mul_ff, 5'd15);
         T_DEN: begin
            neg_ff <= num[31] ^ den[31];
            if (den == 32'd0) begin
               val_ff <= '0;
               err_ff <= 1'b1;
            end
         end
         T_FIN: begin
            val_ff <= asr(b5 + 32'd8, 5'd4);
            err_ff <= 1'b0;
         end
         P_B6:    b6_ff <= temp_term_ff - TEMP_OFS;
         P_SQ:    sq_ff <= asr(mul_ff, 5'd12);
         P_X2MUL: x1_ff <= asr(mul_ff, 5'd11);
         P_B3:    b3_ff <= asr((b3_sum << oss_ff) + 32'd2, 5'd2);
         P_X2B:   x1_ff <= asr(mul_ff, 5'd13);
         P_X3:    x1_ff <= asr(x1_ff + asr(mul_ff, 5'd16) + 32'd2, 5'd2);
         P_B4:    b4_ff <= mul_ff >> 15;
         P_B7MUL: begin
            if (b4_ff == 32'd0) begin
               val_ff <= '0;
               err_ff <= 1'b1;
            end
         end
         P_B7:    pmsb_ff <= mul_ff[31];
         P_PFIX:  p_ff <= pmsb_ff ? {quo[30:0], 1'b0} : quo;
         P_X1C:   x1_ff <= asr(mul_ff, 5'd16);
         P_FIN: begin
            val_ff <= p_ff + asr(x1_ff + asr(mul_ff, 5'd16) + POLY_C, 5'd4);
            err_ff <= 1'b0;
         end
         default: ;
      endcase
   end

   btpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .quotient (quo),
      .done     (div_done)
   );

   assign sts.den_zero = (den == 32'd0);
   assign sts.b4_zero = (b4_ff == 32'd0);
   assign sts.div_done = div_done;

   assign out_kind = kind_ff;
   assign out_value = val_ff;
   assign out_err = err_ff;

endmodule

// ----- rtl/core/btpc_ctrl.sv -----
module btpc_ctrl
   import btpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_action,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= OP_NONE;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
      end
   end

   // next state and next step
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RUN;
               op_in = (req_action == KIND_TEMP) ? T_MUL : P_B6;
            end
         end
         S_RUN: begin
            priority if (op_ff == T_DEN) begin
               if (sts.den_zero) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_DIV;
                  op_in = T_FIN;
               end
            end else if (op_ff == P_B7MUL && sts.b4_zero) begin
               state_in = S_OUT;
            end else if (op_ff == P_B7) begin
               state_in = S_DIV;
               op_in = P_PFIX;
            end else if (op_ff == T_FIN || op_ff == P_FIN) begin
               state_in = S_OUT;
            end else begin
               op_in = op_type'(op_ff + 5'd1);
            end
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_RUN;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
               op_in = OP_NONE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd.op = (state_ff == S_RUN) ? op_ff : OP_NONE;
      cmd.load = (state_ff == S_IDLE) && req_valid;
      cmd.div_start = (state_ff == S_RUN) &&
                      ((op_ff == T_DEN && !sts.den_zero) || op_ff == P_B7);
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_OUT);
   end

endmodule
